// ===== design/pro_pkg.sv =====
// shared types and constants for the progressive refinement order block
// no dependencies; imported by pro_splitter and progressive_refinement_order
`default_nettype none

package pro_pkg;

  localparam int CFG_W           = 9;
  localparam int PIX_W           = 8;
  localparam int DIM_W           = 9;
  localparam int MAX_DIM_DEF     = 256;
  localparam int QUEUE_DEPTH_DEF = 131072;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 9'd256;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // child order of one split: top-left, bottom-left, top-right, bottom-right
  typedef enum logic [1:0] {
    CHILD_TL = 2'd0,
    CHILD_BL = 2'd1,
    CHILD_TR = 2'd2,
    CHILD_BR = 2'd3
  } child_t;

  typedef struct packed {
    logic   present;
    logic   last;
    child_t next;
  } split_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SPLIT = 2'd1,
    ST_PUSH  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== design/pro_rect_mem.sv =====
// single-port rectangle queue storage, registered read
// depends on nothing; instantiated by progressive_refinement_order
`default_nettype none

module pro_rect_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17,
  parameter int EW    = 35
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [EW-1:0] wdata,
  output logic      [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/pro_splitter.sv =====
// quadtree split of one rectangle: origin, size, flag and walk control of one chosen child
// depends on pro_pkg; instantiated by progressive_refinement_order
`default_nettype none

module pro_splitter #(
  parameter int CW = 8,
  parameter int DW = 9
) (
  input  wire logic [CW-1:0]        x,
  input  wire logic [CW-1:0]        y,
  input  wire logic [DW-1:0]        w,
  input  wire logic [DW-1:0]        h,
  input  wire pro_pkg::child_t      child,
  output logic      [CW-1:0]        cx,
  output logic      [CW-1:0]        cy,
  output logic      [DW-1:0]        cw,
  output logic      [DW-1:0]        ch,
  output logic                      cflag,
  output pro_pkg::split_ctl_t       ctl
);

  import pro_pkg::*;

  logic          right;
  logic          bottom;
  logic [DW-1:0] w_ceil;
  logic [DW-1:0] h_ceil;
  logic [DW-1:0] wl;
  logic [DW-1:0] wr;
  logic [DW-1:0] ht;
  logic [DW-1:0] hb;
  logic [CW-1:0] x_mid;
  logic [CW-1:0] y_mid;

  always_comb begin
    right  = w > DW'(1);
    bottom = h > DW'(1);
    w_ceil = DW'(({1'b0, w} + (DW+1)'(1)) >> 1);
    h_ceil = DW'(({1'b0, h} + (DW+1)'(1)) >> 1);
    wl     = right  ? w_ceil : w;
    ht     = bottom ? h_ceil : h;
    wr     = w >> 1;
    hb     = h >> 1;
    // the far half, when present, starts inside the frame, so it fits the coordinate width
    x_mid  = CW'(32'(x) + 32'(w_ceil));
    y_mid  = CW'(32'(y) + 32'(h_ceil));
  end

  always_comb begin
    case (child)
      CHILD_TL: begin
        cx          = x;
        cy          = y;
        cw          = wl;
        ch          = ht;
        cflag       = 1'b0;
        ctl.present = right || bottom;
        ctl.last    = !right && !bottom;
        ctl.next    = bottom ? CHILD_BL : CHILD_TR;
      end
      CHILD_BL: begin
        cx          = x;
        cy          = y_mid;
        cw          = wl;
        ch          = hb;
        cflag       = 1'b1;
        ctl.present = bottom;
        ctl.last    = !right;
        ctl.next    = CHILD_TR;
      end
      CHILD_TR: begin
        cx          = x_mid;
        cy          = y;
        cw          = wr;
        ch          = ht;
        cflag       = 1'b1;
        ctl.present = right;
        ctl.last    = !bottom;
        ctl.next    = CHILD_BR;
      end
      default: begin
        cx          = x_mid;
        cy          = y_mid;
        cw          = wr;
        ch          = hb;
        cflag       = 1'b1;
        ctl.present = right && bottom;
        ctl.last    = 1'b1;
        ctl.next    = CHILD_BR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/progressive_refinement_order.sv =====
// Progressive quadtree refinement order. Each request carries one bit, restart.
// A restart request empties the rectangle queue and seeds it with the whole frame
// (frame_width x frame_height, a zero counts as 1, values above MAX_DIM as MAX_DIM);
// it gives no result. Any other request pops one rectangle,
// pushes its up to four children (the top-left child unflagged) and, if the
// popped rectangle was flagged, returns its origin and size. An advance on an
// empty queue returns finished=1 with all other fields zero.
// Requests are taken one at a time. An advance on an empty queue goes straight
// to loading its result. Any other advance reads the popped rectangle from the
// single-port queue memory, then writes one child per step, then loads its result
// if the popped rectangle was flagged; a request with no result skips that load.
// A result sits in an output register until the receiver takes it; while the
// receiver stalls, the block can still accept and work on the next request and
// only waits when that request's own result is ready.
// Reset (synchronous, active high) empties the queue, drops any pending result
// and sets both frame registers to 256. Memory contents need no clearing.
// Configuration writes are registered; users make them only while idle (unchecked).
// depends on pro_pkg, pro_rect_mem and pro_splitter
`default_nettype none

module progressive_refinement_order #(
  parameter int MAX_DIM     = pro_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = pro_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [pro_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic                        restart,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output logic      [pro_pkg::PIX_W-1:0]   pixel_x,
  output logic      [pro_pkg::PIX_W-1:0]   pixel_y,
  output logic      [pro_pkg::DIM_W-1:0]   block_w,
  output logic      [pro_pkg::DIM_W-1:0]   block_h,
  output logic                             finished
);

  import pro_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int EW   = 2 * CW + 2 * DW + 1;
  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  localparam int OFS_X = 2 * CW + 2 * DW + 1;
  localparam int OFS_Y = CW + 2 * DW + 1;
  localparam int OFS_W = 2 * DW + 1;
  localparam int OFS_H = DW + 1;

  localparam logic [AW-1:0]   PTR_LAST   = AW'(QUEUE_DEPTH - 1);
  localparam logic [CNTW-1:0] COUNT_FULL = CNTW'(QUEUE_DEPTH);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [CNTW-1:0] count;

  // popped rectangle
  logic [CW-1:0] e_x;
  logic [CW-1:0] e_y;
  logic [DW-1:0] e_w;
  logic [DW-1:0] e_h;
  logic          e_flag;
  logic          fin;
  child_t        cidx;

  logic          accept;
  logic          queue_empty;
  logic          queue_full;
  logic          do_restart;
  logic          do_pop;
  logic          do_push;
  logic          load_out;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  logic [CW-1:0] rd_x;
  logic [CW-1:0] rd_y;
  logic [DW-1:0] rd_w;
  logic [DW-1:0] rd_h;
  logic          rd_flag;

  logic [CW-1:0] c_x;
  logic [CW-1:0] c_y;
  logic [DW-1:0] c_w;
  logic [DW-1:0] c_h;
  logic          c_flag;
  split_ctl_t    ctl;

  logic [DW-1:0] seed_w;
  logic [DW-1:0] seed_h;

  pro_rect_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .EW    (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pro_splitter #(
    .CW (CW),
    .DW (DW)
  ) u_split (
    .x     (e_x),
    .y     (e_y),
    .w     (e_w),
    .h     (e_h),
    .child (cidx),
    .cx    (c_x),
    .cy    (c_y),
    .cw    (c_w),
    .ch    (c_h),
    .cflag (c_flag),
    .ctl   (ctl)
  );

  assign rd_x    = mem_rdata[OFS_X-1 -: CW];
  assign rd_y    = mem_rdata[OFS_Y-1 -: CW];
  assign rd_w    = mem_rdata[OFS_W-1 -: DW];
  assign rd_h    = mem_rdata[OFS_H-1 -: DW];
  assign rd_flag = mem_rdata[0];

  assign req_stall   = (state != ST_IDLE);
  assign accept      = req_valid && !req_stall;
  assign queue_empty = (count == '0);
  assign queue_full  = (count == COUNT_FULL);

  // frame size clamped to 1..MAX_DIM
  always_comb begin
    if (frame_width == '0) begin
      seed_w = DW'(1);
    end else if (32'(frame_width) > MAX_DIM) begin
      seed_w = DW'(MAX_DIM);
    end else begin
      seed_w = DW'(frame_width);
    end
    if (frame_height == '0) begin
      seed_h = DW'(1);
    end else if (32'(frame_height) > MAX_DIM) begin
      seed_h = DW'(MAX_DIM);
    end else begin
      seed_h = DW'(frame_height);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !restart) begin
          state_next = queue_empty ? ST_DONE : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (rd_w > DW'(1) || rd_h > DW'(1)) begin
          state_next = ST_PUSH;
        end else begin
          state_next = rd_flag ? ST_DONE : ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (ctl.last) begin
          state_next = e_flag ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    do_restart = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = head;
    mem_wdata  = {c_x, c_y, c_w, c_h, c_flag};
    case (state)
      ST_IDLE: begin
        if (accept && restart) begin
          do_restart = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = '0;
          mem_wdata  = {{CW{1'b0}}, {CW{1'b0}}, seed_w, seed_h, 1'b1};
        end else if (accept && !queue_empty) begin
          do_pop = 1'b1;
        end
      end
      ST_PUSH: begin
        // a child that finds the queue full is dropped
        do_push  = ctl.present && !queue_full;
        mem_we   = do_push;
        mem_addr = tail;
      end
      ST_DONE: begin
        load_out = !res_valid || !res_stall;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= FRAME_DIM_RESET;
      frame_height <= FRAME_DIM_RESET;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          frame_width  <= frame_width;
        endcase
      end
      if (do_restart) begin
        head  <= '0;
        tail  <= AW'(1);
        count <= CNTW'(1);
      end else if (do_pop) begin
        head  <= (head == PTR_LAST) ? '0 : head + AW'(1);
        count <= count - CNTW'(1);
      end else if (do_push) begin
        tail  <= (tail == PTR_LAST) ? '0 : tail + AW'(1);
        count <= count + CNTW'(1);
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin <= queue_empty;
    end
    if (state == ST_SPLIT) begin
      e_x    <= rd_x;
      e_y    <= rd_y;
      e_w    <= rd_w;
      e_h    <= rd_h;
      e_flag <= rd_flag;
      cidx   <= CHILD_TL;
    end else if (state == ST_PUSH) begin
      cidx <= ctl.next;
    end
    if (load_out) begin
      if (fin) begin
        pixel_x  <= '0;
        pixel_y  <= '0;
        block_w  <= '0;
        block_h  <= '0;
        finished <= 1'b1;
      end else begin
        pixel_x  <= PIX_W'(e_x);
        pixel_y  <= PIX_W'(e_y);
        block_w  <= DIM_W'(e_w);
        block_h  <= DIM_W'(e_h);
        finished <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
